FILE: sv/assert_macros.svh
// Assertion macros used by the checker module pli_checker.
// Depends on signals named clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: sv/pli_pkg.sv
// Shared types and constants for the profile linear interpolator.
// No dependencies.
package pli_pkg;

    localparam int TABLE_ROWS_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_W         = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic
    {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_type_t;

    typedef enum logic [1:0]
    {
        STATUS_OK     = 2'd0,
        STATUS_STORED = 2'd1,
        STATUS_FULL   = 2'd2,
        STATUS_FEW    = 2'd3
    } status_t;

endpackage

FILE: sv/pli_if.sv
// Request and response channel interfaces, valid/ready handshake.
// Depends on pli_pkg.
interface pli_req_if;
    import pli_pkg::*;

    logic      valid;
    logic      ready;
    req_type_t req_type;
    data_t     row_position;
    data_t     row_velocity;
    data_t     row_structure;
    data_t     query_position;

    modport source
    (
        output valid, req_type, row_position, row_velocity, row_structure, query_position,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, row_position, row_velocity, row_structure, query_position,
        output ready
    );
endinterface

interface pli_rsp_if;
    import pli_pkg::*;

    logic    valid;
    logic    ready;
    data_t   velocity_out;
    data_t   structure_out;
    status_t status;

    modport source
    (
        output valid, velocity_out, structure_out, status,
        input  ready
    );

    modport sink
    (
        input  valid, velocity_out, structure_out, status,
        output ready
    );
endinterface

FILE: sv/pli_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: sv/profile_linear_interpolator.sv
// Piecewise linear interpolation table with two value columns, all signed fixed point.
// Depends on pli_pkg, pli_if (pli_req_if, pli_rsp_if) and pli_ram.
//
// Loads append one row (position, velocity, structure) to the table and
// answer with status stored, or table full once TABLE_ROWS rows are held.
// A query needs at least two rows and positions in ascending order; it is
// clamped to the first or last row, else interpolated between the rows found
// by binary search. One item is worked on at a time; the next may be taken
// while the previous result still waits at the output. An interior query
// reads the position memory through its single read port and then compares
// for each search step, then the divider yields one quotient bit per cycle,
// then one shared multiplier serves both columns in turn. Memory contents
// need no clearing after reset.
module profile_linear_interpolator #(
    parameter int TABLE_ROWS = pli_pkg::TABLE_ROWS_DEF,
    parameter int FRAC_BITS  = pli_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    pli_req_if.sink        req,
    pli_rsp_if.source      rsp
);
    import pli_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_ROWS);
    localparam int CNT_W  = $clog2(TABLE_ROWS + 1);
    localparam int DIVC_W = $clog2(FRAC_BITS);
    localparam int T_W    = FRAC_BITS + 1;
    localparam int DY_W   = DATA_W + 1;
    localparam int PROD_W = T_W + 1 + DY_W;

    localparam logic [CNT_W-1:0]         ROWS_MAX = CNT_W'(TABLE_ROWS);
    localparam logic [CNT_W-1:0]         ROWS_MIN = CNT_W'(2);
    localparam logic [DIVC_W-1:0]        DIV_LAST = DIVC_W'(FRAC_BITS - 1);
    localparam logic [T_W-1:0]           T_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [PROD_W-1:0] HALF     = PROD_W'(64'd1 << (FRAC_BITS - 1));

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SEARCH,
        S_CMP,
        S_RDHI,
        S_DIVI,
        S_DIV,
        S_MUL,
        S_ACC,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   rows_reg;
    logic               out_valid_reg;
    data_t              out_vel_reg;
    data_t              out_str_reg;
    status_t            out_status_reg;

    data_t              q_reg;
    data_t              plo_reg;
    data_t              phi_reg;
    logic [ADDR_W-1:0]  lo_reg;
    logic [ADDR_W-1:0]  hi_reg;
    logic [2*DATA_W-1:0] ylo_reg;
    logic [2*DATA_W-1:0] yhi_reg;
    logic [DATA_W-1:0]  rem_reg;
    logic [DATA_W-1:0]  den_reg;
    logic [T_W-1:0]     quo_reg;
    logic [DIVC_W-1:0]  div_cnt_reg;
    logic               mul_sel_reg;
    logic signed [PROD_W-1:0] prod_reg;
    data_t              res_vel_reg;
    data_t              res_str_reg;
    status_t            res_status_reg;

    logic                accept;
    logic                full;
    logic                few;
    logic                we;
    logic [ADDR_W-1:0]   last_addr;
    logic [ADDR_W:0]     mid_sum;
    logic [ADDR_W-1:0]   mid;
    logic [ADDR_W-1:0]   span;
    logic                wide_span;
    logic [ADDR_W-1:0]   pos_raddr;
    logic [ADDR_W-1:0]   val_raddr;
    logic [DATA_W-1:0]   pos_rdata;
    logic [2*DATA_W-1:0] val_rdata;
    data_t               pos_rd;
    data_t               val_rd_vel;
    data_t               val_rd_str;
    logic                q_le_first;
    logic                q_ge_last;

    logic signed [DY_W-1:0] num;
    logic signed [DY_W-1:0] den;
    logic                   t_zero;
    logic                   t_one;
    logic                   t_direct;
    logic [DATA_W:0]        rem2;
    logic                   rem_ge;
    logic [DATA_W:0]        rem_sub;

    data_t                    ylo_sel;
    data_t                    yhi_sel;
    logic signed [DY_W-1:0]   dy;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] acc;

    assign accept    = req.valid && req.ready;
    assign full      = (rows_reg == ROWS_MAX);
    assign few       = (rows_reg < ROWS_MIN);
    assign we        = accept && (req.req_type == REQ_LOAD) && !full;
    assign last_addr = ADDR_W'(rows_reg - CNT_W'(1));
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[ADDR_W:1];
    assign span      = hi_reg - lo_reg;
    assign wide_span = (span > ADDR_W'(1));

    always_comb
    begin
        pos_raddr = '0;
        val_raddr = '0;
        case (state_reg)
            S_FIRST:
            begin
                pos_raddr = last_addr;
                val_raddr = last_addr;
            end
            S_SEARCH:
            begin
                pos_raddr = mid;
                val_raddr = lo_reg;
            end
            S_RDHI:
            begin
                val_raddr = hi_reg;
            end
            default:
            begin
                pos_raddr = '0;
                val_raddr = '0;
            end
        endcase
    end

    pli_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_ROWS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (we),
        .waddr (rows_reg[ADDR_W-1:0]),
        .wdata (req.row_position),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    pli_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (TABLE_ROWS)
    ) u_val_ram (
        .clk   (clk),
        .we    (we),
        .waddr (rows_reg[ADDR_W-1:0]),
        .wdata ({req.row_velocity, req.row_structure}),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    assign pos_rd     = $signed(pos_rdata);
    assign val_rd_vel = $signed(val_rdata[2*DATA_W-1:DATA_W]);
    assign val_rd_str = $signed(val_rdata[DATA_W-1:0]);
    assign q_le_first = (q_reg <= pos_rd);
    assign q_ge_last  = (q_reg >= pos_rd);

    assign num      = DY_W'(q_reg) - DY_W'(plo_reg);
    assign den      = DY_W'(phi_reg) - DY_W'(plo_reg);
    assign t_zero   = (den <= 0) || (num <= 0);
    assign t_one    = (num >= den);
    assign t_direct = t_zero || t_one;
    assign rem2     = {rem_reg, 1'b0};
    assign rem_ge   = (rem2 >= {1'b0, den_reg});
    assign rem_sub  = rem2 - {1'b0, den_reg};

    assign ylo_sel   = mul_sel_reg ? $signed(ylo_reg[DATA_W-1:0])
                                   : $signed(ylo_reg[2*DATA_W-1:DATA_W]);
    assign yhi_sel   = mul_sel_reg ? $signed(yhi_reg[DATA_W-1:0])
                                   : $signed(yhi_reg[2*DATA_W-1:DATA_W]);
    assign dy        = DY_W'(yhi_sel) - DY_W'(ylo_sel);
    assign prod_next = PROD_W'($signed({1'b0, quo_reg})) * PROD_W'(dy);
    assign acc       = PROD_W'(ylo_sel) + ((prod_reg + HALF) >>> FRAC_BITS);

    // Control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rows_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_vel_reg    <= '0;
            out_str_reg    <= '0;
            out_status_reg <= STATUS_OK;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        if (req.req_type == REQ_LOAD)
                        begin
                            if (!full)
                            begin
                                rows_reg <= rows_reg + CNT_W'(1);
                            end
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= few ? S_DONE : S_FIRST;
                        end
                    end
                end
                S_FIRST:  state_reg <= q_le_first ? S_DONE : S_LAST;
                S_LAST:   state_reg <= q_ge_last ? S_DONE : S_SEARCH;
                S_SEARCH: state_reg <= wide_span ? S_CMP : S_RDHI;
                S_CMP:    state_reg <= S_SEARCH;
                S_RDHI:   state_reg <= S_DIVI;
                S_DIVI:   state_reg <= t_direct ? S_MUL : S_DIV;
                S_DIV:
                begin
                    if (div_cnt_reg == DIV_LAST)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:    state_reg <= S_ACC;
                S_ACC:    state_reg <= mul_sel_reg ? S_DONE : S_MUL;
                S_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_vel_reg    <= res_vel_reg;
                        out_str_reg    <= res_str_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // Search, divide and blend datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    q_reg       <= req.query_position;
                    res_vel_reg <= '0;
                    res_str_reg <= '0;
                    if (req.req_type == REQ_LOAD)
                    begin
                        res_status_reg <= full ? STATUS_FULL : STATUS_STORED;
                    end
                    else
                    begin
                        res_status_reg <= few ? STATUS_FEW : STATUS_OK;
                    end
                end
            end
            S_FIRST:
            begin
                if (q_le_first)
                begin
                    res_vel_reg <= val_rd_vel;
                    res_str_reg <= val_rd_str;
                end
                else
                begin
                    plo_reg <= pos_rd;
                end
            end
            S_LAST:
            begin
                if (q_ge_last)
                begin
                    res_vel_reg <= val_rd_vel;
                    res_str_reg <= val_rd_str;
                end
                else
                begin
                    phi_reg <= pos_rd;
                    lo_reg  <= '0;
                    hi_reg  <= last_addr;
                end
            end
            S_CMP:
            begin
                if (pos_rd <= q_reg)
                begin
                    lo_reg  <= mid;
                    plo_reg <= pos_rd;
                end
                else
                begin
                    hi_reg  <= mid;
                    phi_reg <= pos_rd;
                end
            end
            S_RDHI:
            begin
                ylo_reg <= val_rdata;
            end
            S_DIVI:
            begin
                yhi_reg     <= val_rdata;
                rem_reg     <= num[DATA_W-1:0];
                den_reg     <= den[DATA_W-1:0];
                div_cnt_reg <= '0;
                mul_sel_reg <= 1'b0;
                if (t_zero)
                begin
                    quo_reg <= '0;
                end
                else if (t_one)
                begin
                    quo_reg <= T_ONE;
                end
                else
                begin
                    quo_reg <= '0;
                end
            end
            S_DIV:
            begin
                rem_reg     <= rem_ge ? rem_sub[DATA_W-1:0] : rem2[DATA_W-1:0];
                quo_reg     <= {quo_reg[T_W-2:0], rem_ge};
                div_cnt_reg <= div_cnt_reg + DIVC_W'(1);
            end
            S_MUL:
            begin
                prod_reg <= prod_next;
            end
            S_ACC:
            begin
                if (mul_sel_reg)
                begin
                    res_str_reg <= acc[DATA_W-1:0];
                end
                else
                begin
                    res_vel_reg <= acc[DATA_W-1:0];
                    mul_sel_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.velocity_out  = out_vel_reg;
    assign rsp.structure_out = out_str_reg;
    assign rsp.status        = out_status_reg;

endmodule

FILE: sv/pli_checker.sv
// Port-level checker for profile_linear_interpolator, attached by bind.
// Depends on pli_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pli_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input pli_pkg::data_t   rsp_velocity_out,
    input pli_pkg::data_t   rsp_structure_out,
    input pli_pkg::status_t rsp_status
);
    import pli_pkg::*;

    `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
    `ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_velocity_out) && $stable(rsp_structure_out) && $stable(rsp_status), "stalled response changed")
    `ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while one is in progress")
    `ASSERT_CLK(a_zero_values, !rsp_valid || rsp_status == STATUS_OK || (rsp_velocity_out == 0 && rsp_structure_out == 0), "non-query result carries values")

endmodule

bind profile_linear_interpolator pli_checker u_pli_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_velocity_out  (rsp.velocity_out),
    .rsp_structure_out (rsp.structure_out),
    .rsp_status        (rsp.status)
);

FILE: bench/profile_linear_interpolator_tb.sv
// Self-checking bench for profile_linear_interpolator: row loads and interpolation queries.
// Tracks its own copy of the table and predicts every response in order.
// Depends on pli_pkg, pli_req_if, pli_rsp_if and the block itself.
module profile_linear_interpolator_tb;
    import pli_pkg::*;

    localparam int    ROWS          = TABLE_ROWS_DEF;
    localparam int    RANDOM_ITEMS  = 1530;
    localparam int    QUIET_TAIL    = 200;
    localparam data_t MOST_NEG      = 32'sh8000_0000;
    localparam data_t MOST_POS      = 32'sh7fff_ffff;
    localparam data_t ONE           = 32'sh0001_0000;

    class profile_table_tracker;
        typedef struct
        {
            data_t   velocity;
            data_t   structure;
            status_t status;
        } answer_t;

        data_t       pos_tab [TABLE_ROWS_DEF];
        data_t       vel_tab [TABLE_ROWS_DEF];
        data_t       str_tab [TABLE_ROWS_DEF];
        int unsigned row_count;
        answer_t     pending_answers [$];
        int unsigned mismatches;

        function new();
            row_count  = 0;
            mismatches = 0;
        endfunction

        function data_t blend_column(data_t y_lo, data_t y_hi, longint frac);
            longint diff;
            longint r;
            diff = longint'(y_hi) - longint'(y_lo);
            r = longint'(y_lo)
                + ((frac * diff + (longint'(1) <<< (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF);
            if (r > longint'(MOST_POS))
                r = longint'(MOST_POS);
            if (r < longint'(MOST_NEG))
                r = longint'(MOST_NEG);
            return r[31:0];
        endfunction

        function void note_request(req_type_t kind, data_t p, data_t v, data_t s, data_t q);
            answer_t     a;
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            int unsigned last;
            longint      num;
            longint      den;
            longint      frac;
            a.velocity  = '0;
            a.structure = '0;
            if (kind == REQ_LOAD)
            begin
                if (row_count < TABLE_ROWS_DEF)
                begin
                    pos_tab[row_count] = p;
                    vel_tab[row_count] = v;
                    str_tab[row_count] = s;
                    row_count++;
                    a.status = STATUS_STORED;
                end
                else
                    a.status = STATUS_FULL;
            end
            else if (row_count < 2)
                a.status = STATUS_FEW;
            else
            begin
                a.status = STATUS_OK;
                last = row_count - 1;
                if (q <= pos_tab[0])
                begin
                    a.velocity  = vel_tab[0];
                    a.structure = str_tab[0];
                end
                else if (q >= pos_tab[last])
                begin
                    a.velocity  = vel_tab[last];
                    a.structure = str_tab[last];
                end
                else
                begin
                    lo = 0;
                    hi = last;
                    while (hi - lo > 1)
                    begin
                        mid = (lo + hi) / 2;
                        if (pos_tab[mid] <= q)
                            lo = mid;
                        else
                            hi = mid;
                    end
                    num = longint'(q) - longint'(pos_tab[lo]);
                    den = longint'(pos_tab[hi]) - longint'(pos_tab[lo]);
                    if (den <= 0 || num <= 0)
                        frac = 0;
                    else if (num >= den)
                        frac = longint'(1) <<< FRAC_BITS_DEF;
                    else
                        frac = (num <<< FRAC_BITS_DEF) / den;
                    a.velocity  = blend_column(vel_tab[lo], vel_tab[hi], frac);
                    a.structure = blend_column(str_tab[lo], str_tab[hi], frac);
                end
            end
            pending_answers.push_back(a);
        endfunction

        function void check_answer(data_t v, data_t s, status_t st);
            answer_t e;
            if (pending_answers.size() == 0)
            begin
                $error("unexpected response: velocity_out %0d structure_out %0d status %0d",
                       v, s, st);
                mismatches++;
                return;
            end
            e = pending_answers.pop_front();
            if (v !== e.velocity)
            begin
                $error("velocity_out: expected %0d, got %0d", e.velocity, v);
                mismatches++;
            end
            if (s !== e.structure)
            begin
                $error("structure_out: expected %0d, got %0d", e.structure, s);
                mismatches++;
            end
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   bursts_on = 1'b1;

    profile_table_tracker tracker;
    data_t                loaded_pos [$];
    longint               pos_cursor;

    pli_req_if req_ch ();
    pli_rsp_if rsp_ch ();

    profile_linear_interpolator i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic data_t any_value();
        case ($urandom_range(0, 9))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic data_t next_position();
        longint step;
        if (loaded_pos.size() >= ROWS)
            return $urandom;
        if (loaded_pos.size() == ROWS - 1)
            return MOST_POS;
        case ($urandom_range(0, 15))
            0:       return $urandom;
            1:       return pos_cursor[31:0];
            2, 3, 4: step = $urandom_range(1, 255);
            default: step = $urandom_range(1, 1 << 24);
        endcase
        pos_cursor = (pos_cursor + step > longint'(MOST_POS)) ? longint'(MOST_POS)
                                                               : pos_cursor + step;
        return pos_cursor[31:0];
    endfunction

    function automatic data_t pick_query();
        int unsigned n;
        int unsigned k;
        longint      lo_p;
        longint      span;
        longint      pick;
        n = loaded_pos.size();
        if (n == 0)
            return $urandom;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return loaded_pos[k];
            3:       return loaded_pos[k] + ($urandom_range(0, 1) ? 1 : -1);
            default:
            begin
                if (k + 1 < n)
                begin
                    lo_p = loaded_pos[k];
                    span = longint'(loaded_pos[k + 1]) - lo_p;
                    if (span > 0)
                    begin
                        pick = lo_p + longint'($urandom_range(0, span[31:0]));
                        return pick[31:0];
                    end
                end
                return loaded_pos[k];
            end
        endcase
    endfunction

    task automatic send_request(req_type_t kind, data_t p, data_t v, data_t s, data_t q);
        if (bursts_on && $urandom_range(0, 7) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= kind;
        req_ch.row_position   <= p;
        req_ch.row_velocity   <= v;
        req_ch.row_structure  <= s;
        req_ch.query_position <= q;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        tracker.note_request(kind, p, v, s, q);
    endtask

    task automatic load_row(data_t p, data_t v, data_t s);
        send_request(REQ_LOAD, p, v, s, $urandom);
        if (loaded_pos.size() < ROWS)
            loaded_pos.push_back(p);
    endtask

    task automatic ask(data_t q);
        send_request(REQ_QUERY, $urandom, $urandom, $urandom, q);
    endtask

    // Stimulus: directed opening, then random loads and queries.
    initial
    begin
        tracker = new();
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= REQ_LOAD;
        req_ch.row_position   <= '0;
        req_ch.row_velocity   <= '0;
        req_ch.row_structure  <= '0;
        req_ch.query_position <= '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        ask('0);
        ask(MOST_NEG);
        load_row(MOST_NEG, MOST_POS, MOST_NEG);
        ask(MOST_POS);
        load_row(-ONE, MOST_NEG, MOST_POS);
        ask(MOST_NEG);
        ask(MOST_NEG + 1);
        ask(-ONE - 32'sh8000);
        ask(-ONE);
        ask(MOST_POS);
        load_row(-ONE, 32'sh0001_8000, -32'sh0000_8001);
        ask(-ONE - 1);
        load_row(ONE, 32'sd3, -32'sd3);
        ask(-ONE);
        ask('0);
        ask(32'sh0000_7fff);
        load_row(3 * ONE, MOST_POS, MOST_NEG);
        ask(3 * ONE - 1);
        ask(ONE);
        pos_cursor = longint'(3 * ONE);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - QUIET_TAIL)
                bursts_on = 1'b0;
            if (loaded_pos.size() < ROWS ? $urandom_range(0, 1) == 0
                                         : $urandom_range(0, 9) == 0)
                load_row(next_position(), any_value(), any_value());
            else
                ask(pick_query());
        end
        req_ch.valid <= 1'b0;

        while (tracker.pending_answers.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_answers.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Response side: stall in random bursts while bursts are enabled.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (bursts_on && $urandom_range(0, 11) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.check_answer(rsp_ch.velocity_out, rsp_ch.structure_out, rsp_ch.status);

    initial
    begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule
